// File: rtl/core/bplf_pkg.sv
package bplf_pkg;

  // Request codes carried by req_type.
  localparam logic REQ_BIN   = 1'b0;
  localparam logic REQ_BOOST = 1'b1;

  // Configuration register indexes (byte address is 4 times the index).
  localparam logic [2:0] REG_BAND_FIRST   = 3'd0;
  localparam logic [2:0] REG_BAND_LAST    = 3'd1;
  localparam logic [2:0] REG_ATTACK_COEF  = 3'd2;
  localparam logic [2:0] REG_RELEASE_COEF = 3'd3;
  localparam logic [2:0] REG_LEVEL_GAIN   = 3'd4;
  localparam logic [2:0] REG_PULSE_AMOUNT = 3'd5;
  localparam logic [2:0] REG_BOOST_DECAY  = 3'd6;

  localparam int unsigned APB_ADDR_W = 5;

  // Fixed-point constants.
  localparam logic [16:0] ONE_Q16         = 17'd65536;
  localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;
  localparam logic [21:0] FLOOR_DB_Q16    = 22'd3932160;
  localparam int unsigned SPAN_DB         = 70;
  localparam logic [15:0] PULSE_MAX       = 16'd40960;
  localparam logic [20:0] LOG2_FULL_Q16   = 21'd1048576;

  // Reciprocal for the divide by the dB span: floor(2^24 / 70).
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned DIV_MUL_I = (1 << DIV_SHIFT) / SPAN_DB;
  localparam logic [17:0] DIV_MUL   = 18'(DIV_MUL_I);

  // Log2 fraction table.
  localparam int unsigned LOG_TBL_BITS    = 6;
  localparam int unsigned LOG_TBL_ENTRIES = 1 << LOG_TBL_BITS;

  // Command queue between the front and the back.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

  typedef logic [15:0] log_tbl_t [LOG_TBL_ENTRIES];

  // Builds floor(log2(1 + i/N) * 65536) by repeated squaring; evaluated at elaboration.
  function automatic log_tbl_t build_log_tbl();
    log_tbl_t    tbl;
    logic [63:0] x;
    logic [15:0] r;
    for (int i = 0; i < LOG_TBL_ENTRIES; i++) begin
      x = (64'd1 << 30) | (64'(i) << (30 - LOG_TBL_BITS));
      r = '0;
      for (int b = 15; b >= 0; b--) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x    = x >> 1;
          r[b] = 1'b1;
        end
      end
      tbl[i] = r;
    end
    return tbl;
  endfunction

  localparam log_tbl_t LOG_FRAC = build_log_tbl();

  typedef struct packed {
    logic [9:0]  band_first;
    logic [9:0]  band_last;
    logic [16:0] attack_coef;
    logic [16:0] release_coef;
    logic [15:0] level_gain;
    logic [15:0] pulse_amount;
    logic [15:0] boost_decay;
  } cfg_t;

  typedef struct packed {
    logic        is_boost;
    logic [15:0] peak;
    logic [7:0]  elapsed_ms;
    logic [16:0] boost_add;
  } cmd_t;

endpackage

// File: rtl/core/bplf_front.sv
module bplf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bplf_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic [9:0]       bin_index_i,
  input  logic [15:0]      bin_amplitude_i,
  input  logic             last_bin_i,
  input  logic [7:0]       elapsed_ms_i,
  input  logic [16:0]      boost_amount_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output bplf_pkg::cmd_t   q_cmd_o
);
  import bplf_pkg::*;

  logic        peak_seen_q, peak_seen_d;
  logic [15:0] peak_q, peak_d;
  logic        accept;
  logic        is_bin;
  logic        in_band;
  logic        seen_now;
  logic [15:0] peak_now;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_bin     = (req_type_i == REQ_BIN);

  // Every 10-bit index is below the bin count, so only the band bounds matter.
  assign in_band = (bin_index_i >= cfg_i.band_first) && (bin_index_i <= cfg_i.band_last);

  always_comb begin
    seen_now = peak_seen_q;
    peak_now = peak_q;
    if (in_band) begin
      seen_now = 1'b1;
      if (!peak_seen_q || (bin_amplitude_i > peak_q)) begin
        peak_now = bin_amplitude_i;
      end
    end
  end

  always_comb begin
    peak_seen_d = peak_seen_q;
    peak_d      = peak_q;
    q_push_o    = 1'b0;
    q_cmd_o     = '0;
    if (accept) begin
      if (!is_bin) begin
        q_push_o          = 1'b1;
        q_cmd_o.is_boost  = 1'b1;
        q_cmd_o.boost_add = boost_amount_i;
      end else if (last_bin_i) begin
        q_push_o           = seen_now;
        q_cmd_o.peak       = peak_now;
        q_cmd_o.elapsed_ms = elapsed_ms_i;
        peak_seen_d        = 1'b0;
        peak_d             = '0;
      end else begin
        peak_seen_d = seen_now;
        peak_d      = peak_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_seen_q <= 1'b0;
      peak_q      <= '0;
    end else begin
      peak_seen_q <= peak_seen_d;
      peak_q      <= peak_d;
    end
  end

endmodule

// File: rtl/core/bplf_cmd_fifo.sv
module bplf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bplf_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bplf_pkg::cmd_t head_o
);
  import bplf_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into a full queue");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (CMD_PTR_W + 1)'(CMD_DEPTH))
    else $error("command queue count exceeds depth");

endmodule

// File: rtl/core/bplf_back.sv
module bplf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bplf_pkg::cfg_t cfg_i,
  input  logic           q_empty_i,
  input  bplf_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [16:0]    effective_level_o,
  output logic [16:0]    smoothed_level_o,
  output logic [18:0]    scale_factor_o
);
  import bplf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOG   = 4'd1;
  localparam logic [3:0] S_ATT   = 4'd2;
  localparam logic [3:0] S_NUM   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_FIX   = 4'd5;
  localparam logic [3:0] S_LVL   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_GAIN  = 4'd8;
  localparam logic [3:0] S_EFF   = 4'd9;
  localparam logic [3:0] S_PULSE = 4'd10;

  logic [3:0]  state_q, state_d;
  logic [16:0] level_q, level_d;
  logic [16:0] boost_q, boost_d;
  logic        out_valid_q, out_valid_d;

  // Working registers of the per-frame sequence.
  logic [15:0] peak_q;
  logic [7:0]  ms_q;
  logic [20:0] diff_q;
  logic [22:0] att_q;
  logic [21:0] num_q;
  logic [23:0] dec_q;
  logic [15:0] quot_q;
  logic [16:0] target_q;
  logic [16:0] step_q;
  logic        up_q;
  logic [19:0] gained_q;
  logic [16:0] eff_q;
  logic [16:0] eff_out_q, lvl_out_q;
  logic [18:0] scale_out_q;

  // Combinational pieces of each step.
  logic [3:0]              lead;
  logic [15:0]             norm;
  logic [LOG_TBL_BITS-1:0] tbl_idx;
  logic [19:0]             lg;
  logic [20:0]             diff_c;
  logic [39:0]             att_prod;
  logic [21:0]             num_c;
  logic [23:0]             dec_c;
  logic [39:0]             div_prod;
  logic [21:0]             quot_x70;
  logic [21:0]             rem_c;
  logic [16:0]             target_c;
  logic                    up_c;
  logic [16:0]             delta_c;
  logic [16:0]             attack_sat, release_sat, coef_c;
  logic [33:0]             step_prod;
  logic [32:0]             gain_prod;
  logic [20:0]             eff_sum;
  logic [16:0]             eff_c;
  logic [15:0]             pulse_sat;
  logic [32:0]             pulse_prod;
  logic [19:0]             scale_c;
  logic [17:0]             boost_sum;
  logic                    out_free;
  logic                    load_out;

  // Leading one of the peak.
  always_comb begin
    lead = '0;
    for (int i = 0; i < 16; i++) begin
      if (peak_q[i]) begin
        lead = 4'(i);
      end
    end
  end

  assign norm    = peak_q << (4'd15 - lead);
  assign tbl_idx = norm[14 -: LOG_TBL_BITS];
  assign lg      = {lead, 16'd0} + 20'(LOG_FRAC[tbl_idx]);
  assign diff_c  = (peak_q == '0) ? LOG2_FULL_Q16 : (LOG2_FULL_Q16 - 21'(lg));

  assign att_prod = 40'(diff_q) * 40'(DB_PER_LOG2_Q16);
  assign num_c    = (23'(FLOOR_DB_Q16) <= att_q) ? '0 : 22'(23'(FLOOR_DB_Q16) - att_q);
  assign dec_c    = 24'(cfg_i.boost_decay) * 24'(ms_q);

  // Divide by the dB span: reciprocal estimate, then one correction step.
  assign div_prod = 40'(num_q) * 40'(DIV_MUL);
  assign quot_x70 = 22'(quot_q) * 22'(SPAN_DB);
  assign rem_c    = num_q - quot_x70;
  assign target_c = (rem_c >= 22'(SPAN_DB)) ? (17'(quot_q) + 17'd1) : 17'(quot_q);

  assign attack_sat  = (cfg_i.attack_coef > ONE_Q16) ? ONE_Q16 : cfg_i.attack_coef;
  assign release_sat = (cfg_i.release_coef > ONE_Q16) ? ONE_Q16 : cfg_i.release_coef;
  assign up_c        = (target_q > level_q);
  assign delta_c     = up_c ? (target_q - level_q) : (level_q - target_q);
  assign coef_c      = up_c ? attack_sat : release_sat;
  assign step_prod   = 34'(delta_c) * 34'(coef_c);

  assign gain_prod = 33'(level_q) * 33'(cfg_i.level_gain);
  assign eff_sum   = 21'(gained_q) + 21'(boost_q);
  assign eff_c     = (eff_sum > 21'(ONE_Q16)) ? ONE_Q16 : eff_sum[16:0];

  assign pulse_sat  = (cfg_i.pulse_amount > PULSE_MAX) ? PULSE_MAX : cfg_i.pulse_amount;
  assign pulse_prod = 33'(eff_q) * 33'(pulse_sat);
  assign scale_c    = 20'(ONE_Q16) + pulse_prod[32:13];

  assign boost_sum = 18'(boost_q) + 18'(q_head_i.boost_add);

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == S_PULSE) && out_free;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    boost_d     = boost_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          if (q_head_i.is_boost) begin
            boost_d = (boost_sum > 18'(ONE_Q16)) ? ONE_Q16 : boost_sum[16:0];
          end else begin
            state_d = S_LOG;
          end
        end
      end
      S_LOG:  state_d = S_ATT;
      S_ATT:  state_d = S_NUM;
      S_NUM:  state_d = S_DIV;
      S_DIV:  state_d = S_FIX;
      S_FIX:  state_d = S_LVL;
      S_LVL:  state_d = S_UPD;
      S_UPD: begin
        level_d = up_q ? (level_q + step_q) : (level_q - step_q);
        boost_d = (boost_q > 17'(dec_q) || dec_q[23:17] != '0)
                  ? ((dec_q[23:17] != '0) ? 17'd0 : (boost_q - dec_q[16:0]))
                  : 17'd0;
        state_d = S_GAIN;
      end
      S_GAIN: state_d = S_EFF;
      S_EFF:  state_d = S_PULSE;
      S_PULSE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      boost_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      boost_q     <= boost_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && !q_head_i.is_boost) begin
      peak_q <= q_head_i.peak;
      ms_q   <= q_head_i.elapsed_ms;
    end
    if (state_q == S_LOG) begin
      diff_q <= diff_c;
    end
    if (state_q == S_ATT) begin
      att_q <= att_prod[38:16];
    end
    if (state_q == S_NUM) begin
      num_q <= num_c;
      dec_q <= dec_c;
    end
    if (state_q == S_DIV) begin
      quot_q <= div_prod[39:24];
    end
    if (state_q == S_FIX) begin
      target_q <= target_c;
    end
    if (state_q == S_LVL) begin
      step_q <= step_prod[32:16];
      up_q   <= up_c;
    end
    if (state_q == S_GAIN) begin
      gained_q <= gain_prod[32:13];
    end
    if (state_q == S_EFF) begin
      eff_q <= eff_c;
    end
    if (load_out) begin
      eff_out_q   <= eff_q;
      lvl_out_q   <= level_q;
      scale_out_q <= scale_c[18:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign effective_level_o = eff_out_q;
  assign smoothed_level_o  = lvl_out_q;
  assign scale_factor_o    = scale_out_q;

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= ONE_Q16)
    else $error("level above full scale");

  a_boost_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    boost_q <= ONE_Q16)
    else $error("boost above full scale");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished frame did not reach the output register");

endmodule

// File: rtl/core/band_peak_level_follower_unit.sv
// Channel    Direction  Handshake               Payload
// input      in         in_valid_i/in_stall_o   req_type, bin_index, bin_amplitude, last_bin,
//                                               elapsed_ms, boost_amount
// result     out        out_valid_o/out_stall_i effective_level, smoothed_level, scale_factor
// config     in         APB psel/penable        paddr, pwdata, prdata, pready (always high)
//
// Bins are taken one per cycle while the four-entry command queue has room.
// A frame with in-band bins runs the back through log, dB, divide by the span,
// attack/release, boost decay, gain and pulse; a boost event is applied in idle.
// A result waiting in the output register holds only the last back step; the
// front keeps taking bins until the queue fills, then raises in_stall_o.
// Reset clears the tracker, the queue, level, boost and valid, and loads defaults.
module band_peak_level_follower_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [9:0]  bin_index_i,
  input  logic [15:0] bin_amplitude_i,
  input  logic        last_bin_i,
  input  logic [7:0]  elapsed_ms_i,
  input  logic [16:0] boost_amount_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] effective_level_o,
  output logic [16:0] smoothed_level_o,
  output logic [18:0] scale_factor_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [bplf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bplf_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       q_push_cmd, q_head;

  // The register file: written in the APB access phase, read back at any time.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_first   <= 10'd0;
      cfg_q.band_last    <= 10'd0;
      cfg_q.attack_coef  <= 17'd32768;
      cfg_q.release_coef <= 17'd6554;
      cfg_q.level_gain   <= 16'd8192;
      cfg_q.pulse_amount <= 16'd819;
      cfg_q.boost_decay  <= 16'd131;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BAND_FIRST:   cfg_q.band_first   <= pwdata[9:0];
        REG_BAND_LAST:    cfg_q.band_last    <= pwdata[9:0];
        REG_ATTACK_COEF:  cfg_q.attack_coef  <= pwdata[16:0];
        REG_RELEASE_COEF: cfg_q.release_coef <= pwdata[16:0];
        REG_LEVEL_GAIN:   cfg_q.level_gain   <= pwdata[15:0];
        REG_PULSE_AMOUNT: cfg_q.pulse_amount <= pwdata[15:0];
        REG_BOOST_DECAY:  cfg_q.boost_decay  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BAND_FIRST:   prdata = 32'(cfg_q.band_first);
      REG_BAND_LAST:    prdata = 32'(cfg_q.band_last);
      REG_ATTACK_COEF:  prdata = 32'(cfg_q.attack_coef);
      REG_RELEASE_COEF: prdata = 32'(cfg_q.release_coef);
      REG_LEVEL_GAIN:   prdata = 32'(cfg_q.level_gain);
      REG_PULSE_AMOUNT: prdata = 32'(cfg_q.pulse_amount);
      REG_BOOST_DECAY:  prdata = 32'(cfg_q.boost_decay);
      default:          prdata = 32'd0;
    endcase
  end

  // The front tracks the band peak and turns frame ends and boost events into
  // commands; the queue keeps them in arrival order so boosts and frames apply
  // to the level state exactly in the order the items came in.
  bplf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .bin_index_i     (bin_index_i),
    .bin_amplitude_i (bin_amplitude_i),
    .last_bin_i      (last_bin_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .boost_amount_i  (boost_amount_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_push_cmd)
  );

  bplf_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  // The back owns level and boost and runs the per-frame arithmetic.
  bplf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_empty_i         (q_empty),
    .q_head_i          (q_head),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .effective_level_o (effective_level_o),
    .smoothed_level_o  (smoothed_level_o),
    .scale_factor_o    (scale_factor_o)
  );

endmodule
